>>> design/s5ua_pkg.sv
// Shared types, codes and constants for the SOCKS5 UDP associate client.
// No dependencies; used by every module of the block.

package s5ua_pkg;

   // Raw event kinds on the request port
   localparam logic [2:0] KIND_OPEN       = 3'd0;
   localparam logic [2:0] KIND_CONNECTED  = 3'd1;
   localparam logic [2:0] KIND_RX_BYTE    = 3'd2;
   localparam logic [2:0] KIND_TICK       = 3'd3;
   localparam logic [2:0] KIND_DISCONNECT = 3'd4;
   localparam logic [2:0] KIND_CLOSE      = 3'd5;

   // Actions on the response port
   localparam logic [2:0] ACT_NONE        = 3'd0;
   localparam logic [2:0] ACT_GREETING    = 3'd1;
   localparam logic [2:0] ACT_CREDENTIALS = 3'd2;
   localparam logic [2:0] ACT_ASSOC_REQ   = 3'd3;
   localparam logic [2:0] ACT_ESTABLISHED = 3'd4;
   localparam logic [2:0] ACT_FAILED      = 3'd5;

   // Error codes
   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_TIMEOUT      = 4'd1;
   localparam logic [3:0] ERR_CLOSED_HS    = 4'd2;
   localparam logic [3:0] ERR_ASSOC_CLOSED = 4'd3;
   localparam logic [3:0] ERR_METHODS_REJ  = 4'd4;
   localparam logic [3:0] ERR_BAD_METHOD   = 4'd5;
   localparam logic [3:0] ERR_AUTH_REJ     = 4'd6;
   localparam logic [3:0] ERR_REPLY        = 4'd7;
   localparam logic [3:0] ERR_BAD_ATYP     = 4'd8;
   localparam logic [3:0] ERR_ZERO_PORT    = 4'd9;

   // Register indexes
   localparam logic [2:0] CSR_OFFER_USERPASS = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT_TICKS  = 3'd1;
   localparam logic [2:0] CSR_PEER_ADDR_HI   = 3'd2;
   localparam logic [2:0] CSR_PEER_ADDR_LO   = 3'd3;
   localparam logic [2:0] CSR_PEER_IS_V6     = 3'd4;

   localparam logic [19:0] TIMEOUT_RESET = 20'd10000;

   // Protocol bytes
   localparam logic [7:0] METHOD_NO_AUTH    = 8'h00;
   localparam logic [7:0] METHOD_USER_PW    = 8'h02;
   localparam logic [7:0] METHOD_NONE_OK    = 8'hFF;
   localparam logic [7:0] ADDR_TYPE_V4      = 8'h01;
   localparam logic [7:0] ADDR_TYPE_V6      = 8'h04;

   // Classified event, as carried from front to back
   typedef enum logic [2:0] {
      EV_OPEN,
      EV_CONNECTED,
      EV_RX_BYTE,
      EV_TICK,
      EV_DISCONNECT,
      EV_CLOSE
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  rx_byte;
   } event_type;

   // Head of the event queue: valid flag and queued event
   typedef struct packed {
      logic      valid;
      event_type ev;
   } evq_head_type;

   typedef struct packed {
      logic        offer_userpass;
      logic [19:0] timeout_ticks;
      logic [63:0] peer_addr_hi;
      logic [63:0] peer_addr_lo;
      logic        peer_is_v6;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  error_code;
      logic [7:0]  reply_code;
      logic [63:0] relay_addr_hi;
      logic [63:0] relay_addr_lo;
      logic        relay_is_v6;
      logic [15:0] relay_port;
   } result_type;

endpackage

>>> design/s5ua_front.sv
// Front end: accepts request beats, classifies the event kind and queues it.
// Depends on s5ua_pkg.

module s5ua_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [2:0]            req_kind,
   input  logic [7:0]            req_rx_byte,
   output s5ua_pkg::evq_head_type head,
   input  logic                  head_pop
);
   import s5ua_pkg::*;

   event_type  q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic        accept;
   logic        known;
   logic        enq;
   logic        deq;
   ev_kind_type kind_dec;

   // Classify the raw kind; unknown kinds are taken and dropped
   always_comb begin
      known    = 1'b1;
      kind_dec = EV_OPEN;
      case (req_kind)
         KIND_OPEN:       kind_dec = EV_OPEN;
         KIND_CONNECTED:  kind_dec = EV_CONNECTED;
         KIND_RX_BYTE:    kind_dec = EV_RX_BYTE;
         KIND_TICK:       kind_dec = EV_TICK;
         KIND_DISCONNECT: kind_dec = EV_DISCONNECT;
         KIND_CLOSE:      kind_dec = EV_CLOSE;
         default:         known    = 1'b0;
      endcase
   end

   assign req_full = (count_ff == 2'd2);
   assign accept   = req_push && !req_full;
   assign enq      = accept && known;
   assign deq      = head_pop && (count_ff != 2'd0);

   // Queue pointers
   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= '{kind: kind_dec, rx_byte: req_rx_byte};
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.ev    = q_ff[rd_ptr_ff];

endmodule

>>> design/s5ua_back.sv
// Back end: handshake sequencer, reply parser, timeout counter, result queue.
// Depends on s5ua_pkg; fed by s5ua_front.

module s5ua_back (
   input  logic                   clock,
   input  logic                   reset,
   input  s5ua_pkg::cfg_type      cfg,
   input  s5ua_pkg::evq_head_type head,
   output logic                   head_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output s5ua_pkg::result_type   rsp
);
   import s5ua_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_METHOD,
      ST_AUTH,
      ST_ASSOC,
      ST_EST,
      ST_FAILED
   } stage_type;

   stage_type   stage_ff, stage_in;
   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  rc_ff, rc_in;
   logic        v6_ff, v6_in;
   logic [63:0] addr_hi_ff, addr_hi_in;
   logic [63:0] addr_lo_ff, addr_lo_in;
   logic [15:0] port_ff, port_in;
   logic [19:0] tcount_ff, tcount_in;
   logic        armed_ff, armed_in;

   result_type  oq_ff [2];
   logic        owr_ptr_ff, ord_ptr_ff;
   logic [1:0]  ocount_ff, ocount_in;

   logic        room;
   logic        step;
   logic        hand;
   logic        res_valid;
   result_type  res;
   logic        fail_req;
   logic [3:0]  fail_code;
   logic [7:0]  fail_rc;
   logic        clear_parse;
   logic [4:0]  pos;
   logic [7:0]  b;
   logic [15:0] port_new;
   logic [63:0] fin_hi, fin_lo;
   logic        fin_v6;
   logic        addr_phase, port_phase;
   logic        opop;

   assign room     = (ocount_ff != 2'd2);
   assign step     = head.valid && room;
   assign head_pop = step;
   assign hand     = (stage_ff == ST_METHOD) || (stage_ff == ST_AUTH) ||
                     (stage_ff == ST_ASSOC);
   assign pos      = pos_ff;
   assign b        = head.ev.rx_byte;
   assign port_new = {port_ff[7:0], b};
   assign addr_phase = v6_ff ? (pos < 5'd20) : (pos < 5'd8);
   assign port_phase = v6_ff ? (pos < 5'd21) : (pos < 5'd9);

   // Relay address at the last port byte, with peer substitution for all zero
   always_comb begin
      fin_v6 = v6_ff;
      fin_hi = v6_ff ? addr_hi_ff : 64'd0;
      fin_lo = v6_ff ? addr_lo_ff : {32'd0, addr_lo_ff[31:0]};
      if ((fin_hi == 64'd0) && (fin_lo == 64'd0)) begin
         fin_v6 = cfg.peer_is_v6;
         fin_hi = cfg.peer_is_v6 ? cfg.peer_addr_hi : 64'd0;
         fin_lo = cfg.peer_is_v6 ? cfg.peer_addr_lo : {32'd0, cfg.peer_addr_lo[31:0]};
      end
   end

   // Event execution
   always_comb begin
      stage_in    = stage_ff;
      pos_in      = pos_ff;
      rc_in       = rc_ff;
      v6_in       = v6_ff;
      addr_hi_in  = addr_hi_ff;
      addr_lo_in  = addr_lo_ff;
      port_in     = port_ff;
      tcount_in   = tcount_ff;
      armed_in    = armed_ff;
      res_valid   = 1'b0;
      res         = '0;
      fail_req    = 1'b0;
      fail_code   = ERR_NONE;
      fail_rc     = 8'd0;
      clear_parse = 1'b0;

      if (step) begin
         case (head.ev.kind)
            EV_OPEN: begin
               clear_parse = 1'b1;
               stage_in    = ST_METHOD;
               tcount_in   = cfg.timeout_ticks;
               armed_in    = 1'b1;
            end
            EV_CONNECTED: begin
               if (stage_ff == ST_METHOD) begin
                  res_valid  = 1'b1;
                  res.action = ACT_GREETING;
               end
            end
            EV_RX_BYTE: begin
               if (hand) begin
                  if (pos_ff != 5'd31) begin
                     pos_in = pos_ff + 5'd1;
                  end
                  if (stage_ff == ST_AUTH) begin
                     if (pos == 5'd1) begin
                        if (b != 8'd0) begin
                           fail_req  = 1'b1;
                           fail_code = ERR_AUTH_REJ;
                        end else begin
                           stage_in    = ST_ASSOC;
                           clear_parse = 1'b1;
                           res_valid   = 1'b1;
                           res.action  = ACT_ASSOC_REQ;
                        end
                     end
                  end else if (stage_ff == ST_METHOD) begin
                     if (pos == 5'd1) begin
                        if (b == METHOD_NONE_OK) begin
                           fail_req  = 1'b1;
                           fail_code = ERR_METHODS_REJ;
                        end else if (b == METHOD_USER_PW && cfg.offer_userpass) begin
                           stage_in    = ST_AUTH;
                           clear_parse = 1'b1;
                           res_valid   = 1'b1;
                           res.action  = ACT_CREDENTIALS;
                        end else if (b == METHOD_NO_AUTH) begin
                           stage_in    = ST_ASSOC;
                           clear_parse = 1'b1;
                           res_valid   = 1'b1;
                           res.action  = ACT_ASSOC_REQ;
                        end else begin
                           fail_req  = 1'b1;
                           fail_code = ERR_BAD_METHOD;
                        end
                     end
                  end else begin
                     // associate reply
                     if (pos == 5'd1) begin
                        rc_in = b;
                     end else if (pos == 5'd3) begin
                        if (rc_ff != 8'd0) begin
                           fail_req  = 1'b1;
                           fail_code = ERR_REPLY;
                           fail_rc   = rc_ff;
                        end else if (b == ADDR_TYPE_V4) begin
                           v6_in = 1'b0;
                        end else if (b == ADDR_TYPE_V6) begin
                           v6_in = 1'b1;
                        end else begin
                           fail_req  = 1'b1;
                           fail_code = ERR_BAD_ATYP;
                        end
                     end else if (pos >= 5'd4) begin
                        if (addr_phase) begin
                           addr_hi_in = {addr_hi_ff[55:0], addr_lo_ff[63:56]};
                           addr_lo_in = {addr_lo_ff[55:0], b};
                        end else begin
                           port_in = port_new;
                           if (!port_phase) begin
                              if (port_new == 16'd0) begin
                                 fail_req  = 1'b1;
                                 fail_code = ERR_ZERO_PORT;
                              end else begin
                                 stage_in          = ST_EST;
                                 armed_in          = 1'b0;
                                 tcount_in         = 20'd0;
                                 clear_parse       = 1'b1;
                                 res_valid         = 1'b1;
                                 res.action        = ACT_ESTABLISHED;
                                 res.relay_addr_hi = fin_hi;
                                 res.relay_addr_lo = fin_lo;
                                 res.relay_is_v6   = fin_v6;
                                 res.relay_port    = port_new;
                              end
                           end
                        end
                     end
                  end
               end
            end
            EV_TICK: begin
               if (armed_ff) begin
                  if (tcount_ff <= 20'd1) begin
                     tcount_in = 20'd0;
                     armed_in  = 1'b0;
                     fail_req  = 1'b1;
                     fail_code = ERR_TIMEOUT;
                  end else begin
                     tcount_in = tcount_ff - 20'd1;
                  end
               end
            end
            EV_DISCONNECT: begin
               if (hand) begin
                  fail_req  = 1'b1;
                  fail_code = ERR_CLOSED_HS;
               end else if (stage_ff == ST_EST) begin
                  fail_req  = 1'b1;
                  fail_code = ERR_ASSOC_CLOSED;
               end
            end
            EV_CLOSE: begin
               armed_in    = 1'b0;
               tcount_in   = 20'd0;
               clear_parse = 1'b1;
               stage_in    = ST_IDLE;
            end
            default: begin
            end
         endcase

         // Failure is reported once; a repeat leaves the state alone
         if (fail_req && stage_ff != ST_FAILED) begin
            stage_in       = ST_FAILED;
            armed_in       = 1'b0;
            tcount_in      = 20'd0;
            clear_parse    = 1'b1;
            res_valid      = 1'b1;
            res            = '0;
            res.action     = ACT_FAILED;
            res.error_code = fail_code;
            res.reply_code = fail_rc;
         end

         if (clear_parse) begin
            pos_in     = 5'd0;
            rc_in      = 8'd0;
            v6_in      = 1'b0;
            addr_hi_in = 64'd0;
            addr_lo_in = 64'd0;
            port_in    = 16'd0;
         end
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff   <= ST_IDLE;
         pos_ff     <= 5'd0;
         rc_ff      <= 8'd0;
         v6_ff      <= 1'b0;
         addr_hi_ff <= 64'd0;
         addr_lo_ff <= 64'd0;
         port_ff    <= 16'd0;
         tcount_ff  <= 20'd0;
         armed_ff   <= 1'b0;
      end else begin
         stage_ff   <= stage_in;
         pos_ff     <= pos_in;
         rc_ff      <= rc_in;
         v6_ff      <= v6_in;
         addr_hi_ff <= addr_hi_in;
         addr_lo_ff <= addr_lo_in;
         port_ff    <= port_in;
         tcount_ff  <= tcount_in;
         armed_ff   <= armed_in;
      end
   end

   // Result queue, two beats deep
   assign opop      = rsp_pop && (ocount_ff != 2'd0);
   assign ocount_in = ocount_ff + {1'b0, res_valid} - {1'b0, opop};

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ptr_ff <= 1'b0;
         ord_ptr_ff <= 1'b0;
         ocount_ff  <= 2'd0;
      end else begin
         if (res_valid) begin
            owr_ptr_ff <= ~owr_ptr_ff;
         end
         if (opop) begin
            ord_ptr_ff <= ~ord_ptr_ff;
         end
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         oq_ff[owr_ptr_ff] <= res;
      end
   end

   assign rsp_empty = (ocount_ff == 2'd0);
   assign rsp       = oq_ff[ord_ptr_ff];

   // The timer runs only during the handshake stages
   a_armed_in_hs: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (stage_ff == ST_METHOD || stage_ff == ST_AUTH || stage_ff == ST_ASSOC))
      else $error("timer armed outside handshake");

   // A stopped timer holds zero
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      !armed_ff |-> (tcount_ff == 20'd0))
      else $error("stopped timer not zero");

   // A failure beat always lands the sequencer in the failed stage
   a_fail_stage: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.action == ACT_FAILED) |=> (stage_ff == ST_FAILED))
      else $error("failure reported without failed stage");

   // No event is executed without room for its result
   a_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (ocount_ff != 2'd2))
      else $error("result queue overrun");

   // Parse state is clear whenever the sequencer is outside the reply stages
   a_parse_clear: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == ST_EST || stage_ff == ST_FAILED || stage_ff == ST_IDLE) |->
      (pos_ff == 5'd0 && port_ff == 16'd0))
      else $error("parse state left over");

endmodule

>>> design/socks5_udp_associate_client_top.sv
// Top level of the SOCKS5 UDP associate client: register file plus front/back.
// Depends on s5ua_pkg, s5ua_front and s5ua_back.
//
//   channel   direction  handshake         payload
//   req_*     in         req_push/req_full kind, rx_byte
//   rsp_*     out        rsp_pop/rsp_empty action, error_code, reply_code, relay_*
//   csr_*     in         csr_wr_en         csr_index, csr_wdata
//
// One event per cycle sustained while results are popped; a result reaches the rsp
// ports through the event queue, then the sequencer into the result queue.
// The sequencer step (one byte or event) sets the rate; both queues are 2 beats.
// Reset is synchronous, active high, and clears queues, sequencer and registers.
// A stalled response side fills the result queue, then the event queue, then
// raises req_full.

module socks5_udp_associate_client_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_action,
   output logic [3:0]  rsp_error_code,
   output logic [7:0]  rsp_reply_code,
   output logic [63:0] rsp_relay_addr_hi,
   output logic [63:0] rsp_relay_addr_lo,
   output logic        rsp_relay_is_v6,
   output logic [15:0] rsp_relay_port,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import s5ua_pkg::*;

   cfg_type      cfg_ff;
   evq_head_type head;
   logic         head_pop;
   result_type   rsp;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offer_userpass <= 1'b0;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
         cfg_ff.peer_addr_hi   <= 64'd0;
         cfg_ff.peer_addr_lo   <= 64'd0;
         cfg_ff.peer_is_v6     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OFFER_USERPASS: cfg_ff.offer_userpass <= csr_wdata[0];
            CSR_TIMEOUT_TICKS:  cfg_ff.timeout_ticks  <= csr_wdata[19:0];
            CSR_PEER_ADDR_HI:   cfg_ff.peer_addr_hi   <= csr_wdata;
            CSR_PEER_ADDR_LO:   cfg_ff.peer_addr_lo   <= csr_wdata;
            CSR_PEER_IS_V6:     cfg_ff.peer_is_v6     <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   s5ua_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_rx_byte (req_rx_byte),
      .head        (head),
      .head_pop    (head_pop)
   );

   s5ua_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_action        = rsp.action;
   assign rsp_error_code    = rsp.error_code;
   assign rsp_reply_code    = rsp.reply_code;
   assign rsp_relay_addr_hi = rsp.relay_addr_hi;
   assign rsp_relay_addr_lo = rsp.relay_addr_lo;
   assign rsp_relay_is_v6   = rsp.relay_is_v6;
   assign rsp_relay_port    = rsp.relay_port;

endmodule
